FILE: sv/length_prefixed_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// length prefixed frame parser: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_PARSER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LPFP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LPFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/lpfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfp_pkg
// types and fixed constants of the length prefixed frame parser
// ----------------------------------------------------------------------------
package lpfp_pkg;

   localparam int BYTE_W  = 8;
   localparam int IDX_W   = 6;
   localparam int RSP_W   = 32;

   localparam logic [BYTE_W-1:0] START_RESET = 8'h61;

   // parser and emitter phases
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_PAY,
      ST_SUM,
      ST_READ,
      ST_SEND
   } state_type;

endpackage

FILE: sv/lpfp_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfp_store
// payload byte store, one write port and one registered read port
// ----------------------------------------------------------------------------
module lpfp_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [lpfp_pkg::BYTE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [lpfp_pkg::BYTE_W-1:0] rd_data
);
   import lpfp_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/length_prefixed_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// byte-serial frame parser: start byte, length, payload, additive checksum;
// good frames are replayed from the payload store as a run of result words
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  rx_byte
//  rsp      out  rsp_tvalid/rsp_tready  msg_id, data_byte, byte_index,
//                                       data_count; last on rsp_tlast
//  csr      in   csr_wr_en              start_byte
//
//  every input word is taken as soon as it is valid while a frame is parsed
//  a good checksum starts a run of max(1, data_count) result words; each
//  is read from the payload store, whose read port is registered, and is
//  then presented, and held for as long as rsp stalls
//  req_tready stays low for the whole run; a stalled result word holds
//  reset is synchronous, active high, and returns the parser to idle
//  with start_byte 'a'; the payload store needs no clearing pass
//
module length_prefixed_frame_parser #(
   parameter int BUF_BYTES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // input byte stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] rx_byte
   // result stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [lpfp_pkg::RSP_W-1:0]  rsp_tdata,   // [7:0] msg_id, [15:8] data_byte,
                                                    // [21:16] byte_index,
                                                    // [27:22] data_count, [31:28] zero
   output logic                        rsp_tlast,   // last word of the frame's run
   // start byte register
   input  logic                        csr_wr_en,
   input  logic [7:0]                  csr_wr_data
);
   import lpfp_pkg::*;

   // addresses and counts below BUF_BYTES
   localparam int AW = $clog2(BUF_BYTES);

   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] start_ff, start_in;
   logic [AW-1:0]     len_ff, len_in;     // accepted frame length
   logic [AW-1:0]     cnt_ff, cnt_in;     // payload bytes stored so far
   logic [BYTE_W-1:0] sum_ff, sum_in;     // running checksum
   logic [BYTE_W-1:0] id_ff, id_in;       // message id, first payload byte
   logic [AW-1:0]     dcnt_ff, dcnt_in;   // data bytes after the id
   logic [AW-1:0]     k_ff, k_in;         // index of the word being emitted

   logic              req_acc;
   logic [AW:0]       cnt_next;
   logic              len_ok;
   logic              is_last;

   logic              mem_wr_en;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [BYTE_W-1:0] mem_rd_data;

   assign req_acc  = req_tvalid & req_tready;
   assign cnt_next = {1'b0, cnt_ff} + {{AW{1'b0}}, 1'b1};
   assign len_ok   = req_tdata < 8'(BUF_BYTES);
   assign is_last  = (dcnt_ff == '0) || (k_ff == dcnt_ff - {{(AW-1){1'b0}}, 1'b1});

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tdata == start_ff) state_in = ST_LEN;
         end
         ST_LEN: begin
            if (req_acc) state_in = len_ok ? ST_PAY : ST_IDLE;
         end
         ST_PAY: begin
            // a zero length still takes the id byte
            if (req_acc && cnt_next >= {1'b0, len_ff}) state_in = ST_SUM;
         end
         ST_SUM: begin
            if (req_acc) state_in = (req_tdata == sum_ff) ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) state_in = is_last ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      start_in = csr_wr_en ? csr_wr_data : start_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      id_in    = id_ff;
      dcnt_in  = dcnt_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tdata == start_ff) begin
               sum_in = req_tdata;
               cnt_in = '0;
            end
         end
         ST_LEN: begin
            if (req_acc && len_ok) begin
               len_in = req_tdata[AW-1:0];
               sum_in = sum_ff + req_tdata;
            end
         end
         ST_PAY: begin
            if (req_acc) begin
               cnt_in = cnt_next[AW-1:0];
               sum_in = sum_ff + req_tdata;
               if (cnt_ff == '0) id_in = req_tdata;
            end
         end
         ST_SUM: begin
            // at least the id is stored here
            dcnt_in = cnt_ff - {{(AW-1){1'b0}}, 1'b1};
            k_in    = '0;
         end
         ST_SEND: begin
            if (rsp_tready && !is_last) k_in = k_ff + {{(AW-1){1'b0}}, 1'b1};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= START_RESET;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      cnt_ff  <= cnt_in;
      sum_ff  <= sum_in;
      id_ff   <= id_in;
      dcnt_ff <= dcnt_in;
      k_ff    <= k_in;
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      mem_rd_en  = 1'b0;
      case (state_ff)
         ST_IDLE, ST_LEN, ST_PAY, ST_SUM: begin
            req_tready = 1'b1;
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
         end
         ST_SEND: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign mem_wr_en   = req_acc && (state_ff == ST_PAY);
   // data bytes sit after the id at address 0
   assign mem_rd_addr = k_ff + {{(AW-1){1'b0}}, 1'b1};

   lpfp_store #(
      .DEPTH (BUF_BYTES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (cnt_ff),
      .wr_data (req_tdata),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // an id-only frame reports a zero data byte
   assign rsp_tdata = {4'b0000,
                       IDX_W'(dcnt_ff),
                       IDX_W'(k_ff),
                       (dcnt_ff == '0) ? {BYTE_W{1'b0}} : mem_rd_data,
                       id_ff};
   assign rsp_tlast = is_last;

endmodule

FILE: sv/lpfp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfp_chk
// port-level checks of the length prefixed frame parser, bound to the top
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_parser_assert.svh"

module lpfp_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [lpfp_pkg::RSP_W-1:0] rsp_tdata,
   input logic                       rsp_tlast
);
   import lpfp_pkg::*;

   logic [IDX_W-1:0] idx;
   logic [IDX_W-1:0] cnt;

   assign idx = rsp_tdata[21:16];
   assign cnt = rsp_tdata[27:22];

   // no byte is taken while a result word is pending
   `LPFP_ASSERT_IMPL(a_no_rx_during_run, clock, reset, rsp_tvalid, !req_tready, "byte taken during result run")

   // a stalled result word holds
   `LPFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result word changed")

   // index stays within the frame's data count
   `LPFP_ASSERT_IMPL(a_idx_range, clock, reset, rsp_tvalid, (idx < cnt) || (cnt == '0 && idx == '0), "byte_index out of range")

   // last marks the final data byte, or the single id-only word
   `LPFP_ASSERT_IMPL(a_last_pos, clock, reset, rsp_tvalid, rsp_tlast == ((cnt == '0) || (idx == cnt - 6'd1)), "tlast misplaced")

endmodule

bind length_prefixed_frame_parser lpfp_chk u_lpfp_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
